// ----- design/fts_pkg.sv -----
package fts_pkg;

  // Signature bytes
  localparam logic [7:0] SIG_F = 8'h46;
  localparam logic [7:0] SIG_L = 8'h4C;
  localparam logic [7:0] SIG_V = 8'h56;

  // Known tag types
  localparam logic [7:0] TYPE_AUDIO  = 8'h08;
  localparam logic [7:0] TYPE_VIDEO  = 8'h09;
  localparam logic [7:0] TYPE_SCRIPT = 8'h12;

  localparam int SKIP_W       = 25;
  localparam int HDR_LEN      = 13;
  localparam int SIG_LEN      = 3;
  localparam int TAG_HDR_TAIL = 8;

  // Bytes between the 'V' and the first tag, and skip load after the extension byte
  localparam logic [SKIP_W-1:0] HDR_SKIP  = SKIP_W'(HDR_LEN - SIG_LEN);
  localparam logic [SKIP_W-1:0] TAIL_SKIP = SKIP_W'(TAG_HDR_TAIL - 1);

  localparam logic [1:0] SIG_NONE = 2'd0;
  localparam logic [1:0] SIG_GOTF = 2'd1;
  localparam logic [1:0] SIG_GOTL = 2'd2;

  localparam logic [1:0] FIELD_LAST = 2'd2;

  typedef enum logic [6:0] {
    PH_SEARCH   = 7'b0000001,
    PH_HDRSKIP  = 7'b0000010,
    PH_TAGSTART = 7'b0000100,
    PH_SIZE     = 7'b0001000,
    PH_STAMP    = 7'b0010000,
    PH_EXT      = 7'b0100000,
    PH_SKIP     = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       resync;
  } item_t;

  typedef struct packed {
    logic        tag_start;
    logic        type_error;
    logic        header_done;
    logic [7:0]  tag_type;
    logic [23:0] payload_len;
    logic [31:0] timestamp;
    logic        in_sync;
  } result_t;

endpackage

// ----- design/flv_tag_stream_parser.sv -----
// Byte-serial FLV tag delineator. One byte of the stream is accepted per clock while
// the output is not stalled, and one result transaction comes out per byte: the byte is
// held in the input register, then its result is registered in the result register; the
// rate of one byte per cycle is set by the parse-state update between the two registers.
// The block hunts for the 'FLV' signature, skips the rest of the 13-byte file preamble,
// then flags each tag's type byte (tag_start, with type_error for types other than
// audio, video or script data), gathers the 24-bit data size, the 24-bit timestamp and
// its extension byte (header_done), and skips 7 plus the data size to the next tag.
// Raising resync with a byte forces that byte to be taken as a tag start in any phase.
// Field outputs show the values after the byte, partial while their bytes arrive.
module flv_tag_stream_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        resync,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        tag_start,
  output logic        type_error,
  output logic        header_done,
  output logic [7:0]  tag_type,
  output logic [23:0] payload_len,
  output logic [31:0] timestamp,
  output logic        in_sync
);

  fts_pkg::item_t   in_item;
  fts_pkg::item_t   item;
  fts_pkg::result_t core_result;
  fts_pkg::result_t result;
  logic             item_valid;
  logic             advance;

  assign in_item.data_byte = data_byte;
  assign in_item.resync    = resync;

  // move the held byte through the parser when the result slot frees up
  assign advance = item_valid && (!out_valid || out_ready);

  fts_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  fts_parse_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .result  (core_result)
  );

  fts_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .result_in (core_result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  assign tag_start   = result.tag_start;
  assign type_error  = result.type_error;
  assign header_done = result.header_done;
  assign tag_type    = result.tag_type;
  assign payload_len = result.payload_len;
  assign timestamp   = result.timestamp;
  assign in_sync     = result.in_sync;

`ifndef SYNTHESIS
  a_terr_on_start: assert property (@(posedge clk) disable iff (rst)
    (out_valid && type_error) |-> tag_start)
    else $error("type_error without tag_start");

  a_start_hdone_excl: assert property (@(posedge clk) disable iff (rst)
    (out_valid && header_done) |-> (!tag_start && in_sync))
    else $error("header_done with tag_start or out of sync");

  a_start_in_sync: assert property (@(posedge clk) disable iff (rst)
    (out_valid && tag_start) |-> in_sync)
    else $error("tag_start while not in sync");

  a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output backpressure");
`endif

endmodule

// ----- design/fts_in_reg.sv -----
module fts_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  fts_pkg::item_t in_item,
  input  logic           advance,
  output logic           item_valid,
  output fts_pkg::item_t item
);

  logic valid;

  assign in_ready   = !valid || advance;
  assign item_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

// ----- design/fts_parse_core.sv -----
module fts_parse_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  fts_pkg::item_t   item,
  output fts_pkg::result_t result
);

  fts_pkg::phase_t                 phase, phase_next;
  logic [1:0]                      sig, sig_next;
  logic [fts_pkg::SKIP_W-1:0]      skip, skip_next;
  logic [1:0]                      field_cnt, field_cnt_next;
  logic [23:0]                     size_acc, size_acc_next;
  logic [31:0]                     stamp_acc, stamp_acc_next;
  logic [7:0]                      type_reg, type_reg_next;
  logic                            tag_begin;
  logic                            start, terr, hdone;
  logic [7:0]                      b;

  assign b         = item.data_byte;
  assign tag_begin = item.resync || (phase == fts_pkg::PH_TAGSTART);

  always_comb begin
    phase_next     = phase;
    sig_next       = sig;
    skip_next      = skip;
    field_cnt_next = field_cnt;
    size_acc_next  = size_acc;
    stamp_acc_next = stamp_acc;
    type_reg_next  = type_reg;
    start          = 1'b0;
    terr           = 1'b0;
    hdone          = 1'b0;

    if (tag_begin) begin
      start          = 1'b1;
      terr           = !(b inside {fts_pkg::TYPE_AUDIO, fts_pkg::TYPE_VIDEO,
                                   fts_pkg::TYPE_SCRIPT});
      type_reg_next  = b;
      size_acc_next  = '0;
      stamp_acc_next = '0;
      field_cnt_next = '0;
      phase_next     = fts_pkg::PH_SIZE;
    end else begin
      case (phase)
        fts_pkg::PH_HDRSKIP, fts_pkg::PH_SKIP: begin
          if (skip <= fts_pkg::SKIP_W'(1)) begin
            skip_next  = '0;
            phase_next = fts_pkg::PH_TAGSTART;
          end else begin
            skip_next = skip - fts_pkg::SKIP_W'(1);
          end
        end
        fts_pkg::PH_SIZE: begin
          size_acc_next = {size_acc[15:0], b};
          if (field_cnt >= fts_pkg::FIELD_LAST) begin
            field_cnt_next = '0;
            phase_next     = fts_pkg::PH_STAMP;
          end else begin
            field_cnt_next = field_cnt + 2'd1;
          end
        end
        fts_pkg::PH_STAMP: begin
          // extension slot is cleared while the low three bytes shift in
          stamp_acc_next = {8'h00, stamp_acc[15:0], b};
          if (field_cnt >= fts_pkg::FIELD_LAST) begin
            field_cnt_next = '0;
            phase_next     = fts_pkg::PH_EXT;
          end else begin
            field_cnt_next = field_cnt + 2'd1;
          end
        end
        fts_pkg::PH_EXT: begin
          stamp_acc_next = {b, stamp_acc[23:0]};
          hdone          = 1'b1;
          skip_next      = {1'b0, size_acc} + fts_pkg::TAIL_SKIP;
          phase_next     = fts_pkg::PH_SKIP;
        end
        default: begin
          // signature hunt; unused codes land here too
          phase_next = fts_pkg::PH_SEARCH;
          if (b == fts_pkg::SIG_V && sig == fts_pkg::SIG_GOTL) begin
            sig_next   = fts_pkg::SIG_NONE;
            skip_next  = fts_pkg::HDR_SKIP;
            phase_next = fts_pkg::PH_HDRSKIP;
          end else if (b == fts_pkg::SIG_L && sig == fts_pkg::SIG_GOTF) begin
            sig_next = fts_pkg::SIG_GOTL;
          end else if (b == fts_pkg::SIG_F) begin
            sig_next = fts_pkg::SIG_GOTF;
          end else begin
            sig_next = fts_pkg::SIG_NONE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= fts_pkg::PH_SEARCH;
      sig       <= fts_pkg::SIG_NONE;
      skip      <= '0;
      field_cnt <= '0;
      size_acc  <= '0;
      stamp_acc <= '0;
      type_reg  <= '0;
    end else if (advance) begin
      phase     <= phase_next;
      sig       <= sig_next;
      skip      <= skip_next;
      field_cnt <= field_cnt_next;
      size_acc  <= size_acc_next;
      stamp_acc <= stamp_acc_next;
      type_reg  <= type_reg_next;
    end
  end

  always_comb begin
    result.tag_start   = start;
    result.type_error  = terr;
    result.header_done = hdone;
    result.tag_type    = type_reg_next;
    result.payload_len = size_acc_next;
    result.timestamp   = stamp_acc_next;
    result.in_sync     = (phase_next != fts_pkg::PH_SEARCH);
  end

endmodule

// ----- design/fts_out_reg.sv -----
module fts_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  fts_pkg::result_t result_in,
  output logic             out_valid,
  input  logic             out_ready,
  output fts_pkg::result_t result
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_in;
    end
  end

endmodule
